// File: hw/rtl/rvalu_pkg.sv
// Shared types and constants of the register-register ALU block.
// No dependencies; every other file of the block refers to it by scoped names.
package rvalu_pkg;

    localparam int REG_COUNT_DEF = 32;
    localparam int REG_IDX_W     = 5;
    localparam int XLEN          = 32;
    localparam int SHAMT_W       = 5;
    localparam logic [SHAMT_W-1:0] SHIFT_MASK = 5'h1F;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_XOR  = 4'd2,
        OP_OR   = 4'd3,
        OP_AND  = 4'd4,
        OP_SLL  = 4'd5,
        OP_SRL  = 4'd6,
        OP_SRA  = 4'd7,
        OP_SLT  = 4'd8,
        OP_SLTU = 4'd9,
        OP_LOAD = 4'd10
    } t_op;

    // Write port of the register file.
    typedef struct packed {
        logic                 en;
        logic [REG_IDX_W-1:0] addr;
        logic [XLEN-1:0]      data;
    } t_wr_req;

    // Resolved source operands, returned in the cycle after the read was issued.
    typedef struct packed {
        logic [XLEN-1:0] a_data;
        logic [XLEN-1:0] b_data;
    } t_rd_rsp;

endpackage

// File: hw/rtl/rvalu_if.sv
// Valid/ready channel interfaces for instruction requests and results.
// Depends on rvalu_pkg for field widths.
interface rvalu_req_if;
    logic                            valid;
    logic                            ready;
    logic [3:0]                      operation;
    logic [rvalu_pkg::REG_IDX_W-1:0] dest_reg;
    logic [rvalu_pkg::REG_IDX_W-1:0] src_reg_a;
    logic [rvalu_pkg::REG_IDX_W-1:0] src_reg_b;
    logic [rvalu_pkg::XLEN-1:0]      load_value;

    modport source (output valid, operation, dest_reg, src_reg_a, src_reg_b, load_value,
                    input ready);
    modport sink   (input valid, operation, dest_reg, src_reg_a, src_reg_b, load_value,
                    output ready);
endinterface

interface rvalu_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [rvalu_pkg::XLEN-1:0] result_value;
    logic                       was_written;

    modport source (output valid, result_value, was_written, input ready);
    modport sink   (input valid, result_value, was_written, output ready);
endinterface

// File: hw/rtl/rvalu_regfile.sv
// Register file: synchronous memory with two registered read ports, one write
// port, per-entry valid bits for the zero reset, and a one-entry write bypass.
// Depends on rvalu_pkg.
module rvalu_regfile #(
    parameter int REG_COUNT = rvalu_pkg::REG_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_rd_en,
    input  logic [rvalu_pkg::REG_IDX_W-1:0] i_rd_addr_a,
    input  logic [rvalu_pkg::REG_IDX_W-1:0] i_rd_addr_b,
    input  rvalu_pkg::t_wr_req              i_wr,
    output rvalu_pkg::t_rd_rsp              o_rd
);
    localparam int ADDR_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int CMP_W  = rvalu_pkg::REG_IDX_W + 1;

    logic [rvalu_pkg::XLEN-1:0]      r_mem [REG_COUNT];
    logic [REG_COUNT-1:0]            r_vld;
    logic [rvalu_pkg::XLEN-1:0]      r_data_a;
    logic [rvalu_pkg::XLEN-1:0]      r_data_b;
    logic                            r_ok_a;
    logic                            r_ok_b;
    logic [rvalu_pkg::REG_IDX_W-1:0] r_addr_a;
    logic [rvalu_pkg::REG_IDX_W-1:0] r_addr_b;
    logic                            r_fwd_vld;
    logic [rvalu_pkg::REG_IDX_W-1:0] r_fwd_addr;
    logic [rvalu_pkg::XLEN-1:0]      r_fwd_data;
    logic                            in_range_a;
    logic                            in_range_b;
    logic                            n_ok_a;
    logic                            n_ok_b;

    // Register zero and indexes beyond the file always read as zero.
    assign in_range_a = ({1'b0, i_rd_addr_a} < CMP_W'(REG_COUNT)) && (i_rd_addr_a != '0);
    assign in_range_b = ({1'b0, i_rd_addr_b} < CMP_W'(REG_COUNT)) && (i_rd_addr_b != '0);
    assign n_ok_a = in_range_a && r_vld[i_rd_addr_a[ADDR_W-1:0]];
    assign n_ok_b = in_range_b && r_vld[i_rd_addr_b[ADDR_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr[ADDR_W-1:0]] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_data_a <= r_mem[i_rd_addr_a[ADDR_W-1:0]];
            r_data_b <= r_mem[i_rd_addr_b[ADDR_W-1:0]];
            r_addr_a <= i_rd_addr_a;
            r_addr_b <= i_rd_addr_b;
        end
        if (i_wr.en) begin
            r_fwd_addr <= i_wr.addr;
            r_fwd_data <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_ok_a    <= 1'b0;
            r_ok_b    <= 1'b0;
            r_fwd_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr[ADDR_W-1:0]] <= 1'b1;
                r_fwd_vld                    <= 1'b1;
            end
            if (i_rd_en) begin
                r_ok_a <= n_ok_a;
                r_ok_b <= n_ok_b;
            end
        end
    end

    // A write landing on the same edge as the read is not seen by the memory
    // read, so the last write is bypassed. Writes never target zero or an
    // out-of-range index, so a hit also implies a valid source.
    always_comb begin
        if (r_fwd_vld && (r_fwd_addr == r_addr_a)) begin
            o_rd.a_data = r_fwd_data;
        end else begin
            o_rd.a_data = r_ok_a ? r_data_a : '0;
        end
        if (r_fwd_vld && (r_fwd_addr == r_addr_b)) begin
            o_rd.b_data = r_fwd_data;
        end else begin
            o_rd.b_data = r_ok_b ? r_data_b : '0;
        end
    end
endmodule

// File: hw/rtl/rvalu_alu.sv
// Combinational ALU for the ten register-register operations plus load.
// Depends on rvalu_pkg.
module rvalu_alu (
    input  rvalu_pkg::t_op              i_op,
    input  logic [rvalu_pkg::XLEN-1:0]  i_a,
    input  logic [rvalu_pkg::XLEN-1:0]  i_b,
    input  logic [rvalu_pkg::XLEN-1:0]  i_load_value,
    output logic [rvalu_pkg::XLEN-1:0]  o_result,
    output logic                        o_op_ok
);
    logic [rvalu_pkg::SHAMT_W-1:0] shamt;

    assign shamt = i_b[rvalu_pkg::SHAMT_W-1:0] & rvalu_pkg::SHIFT_MASK;

    always_comb begin
        o_op_ok = 1'b1;
        case (i_op)
            rvalu_pkg::OP_ADD:  o_result = i_a + i_b;
            rvalu_pkg::OP_SUB:  o_result = i_a - i_b;
            rvalu_pkg::OP_XOR:  o_result = i_a ^ i_b;
            rvalu_pkg::OP_OR:   o_result = i_a | i_b;
            rvalu_pkg::OP_AND:  o_result = i_a & i_b;
            rvalu_pkg::OP_SLL:  o_result = i_a << shamt;
            rvalu_pkg::OP_SRL:  o_result = i_a >> shamt;
            rvalu_pkg::OP_SRA:  o_result = $unsigned($signed(i_a) >>> shamt);
            rvalu_pkg::OP_SLT:  o_result = {{(rvalu_pkg::XLEN-1){1'b0}},
                                            ($signed(i_a) < $signed(i_b))};
            rvalu_pkg::OP_SLTU: o_result = {{(rvalu_pkg::XLEN-1){1'b0}}, (i_a < i_b)};
            rvalu_pkg::OP_LOAD: o_result = i_load_value;
            default: begin
                // Unassigned codes store nothing and report zero.
                o_result = '0;
                o_op_ok  = 1'b0;
            end
        endcase
    end
endmodule

// File: hw/rtl/rv32i_register_alu_execute.sv
// Register-register ALU with a private register file.
// Pipeline: the memory read, then execute and write back, each ending in a register.
// Throughput: one request per cycle while the consumer keeps up; the write-back bypass
// in the register file keeps dependent back-to-back requests at full rate.
// Reset (synchronous, active low) clears the pipeline valids and every register-file
// valid bit at once, so all registers read as zero right after reset; no clearing pass.
module rv32i_register_alu_execute #(
    parameter int REG_COUNT = rvalu_pkg::REG_COUNT_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rvalu_req_if.sink    i_req,
    rvalu_rsp_if.source  o_rsp
);
    localparam int CMP_W = rvalu_pkg::REG_IDX_W + 1;

    // Execute stage: the request whose operands are being read from the file.
    logic                            r_s1_vld;
    rvalu_pkg::t_op                  r_s1_op;
    logic [rvalu_pkg::REG_IDX_W-1:0] r_s1_rd;
    logic [rvalu_pkg::XLEN-1:0]      r_s1_load;

    // Output register: a finished result waiting to be taken.
    logic                            r_out_vld;
    logic [rvalu_pkg::XLEN-1:0]      r_out_result;
    logic                            r_out_written;

    logic                            accept;
    logic                            s1_advance;
    logic                            out_free;
    logic [rvalu_pkg::XLEN-1:0]      alu_result;
    logic                            alu_op_ok;
    logic                            n_out_written;
    rvalu_pkg::t_wr_req              wr_req;
    rvalu_pkg::t_rd_rsp              rd_rsp;

    // The output register frees up in the same cycle its result is taken, so the
    // pipeline keeps moving while the consumer keeps up.
    assign out_free   = !r_out_vld || o_rsp.ready;
    assign s1_advance = r_s1_vld && out_free;
    assign i_req.ready = !r_s1_vld || s1_advance;
    assign accept     = i_req.valid && i_req.ready;

    // Operand reads are issued as the request is taken; the data comes back
    // registered in the next cycle, together with the bypassed last write.
    rvalu_regfile #(
        .REG_COUNT (REG_COUNT)
    ) u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (accept),
        .i_rd_addr_a (i_req.src_reg_a),
        .i_rd_addr_b (i_req.src_reg_b),
        .i_wr        (wr_req),
        .o_rd        (rd_rsp)
    );

    rvalu_alu u_alu (
        .i_op         (r_s1_op),
        .i_a          (rd_rsp.a_data),
        .i_b          (rd_rsp.b_data),
        .i_load_value (r_s1_load),
        .o_result     (alu_result),
        .o_op_ok      (alu_op_ok)
    );

    // Write back only when the request leaves the execute stage, so a stalled
    // request never writes twice and the bypass always holds the latest write.
    // Register zero, indexes beyond the file and unassigned codes store nothing.
    assign n_out_written = alu_op_ok && (r_s1_rd != '0)
                         && ({1'b0, r_s1_rd} < CMP_W'(REG_COUNT));
    assign wr_req.en   = s1_advance && n_out_written;
    assign wr_req.addr = r_s1_rd;
    assign wr_req.data = alu_result;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op   <= rvalu_pkg::t_op'(i_req.operation);
            r_s1_rd   <= i_req.dest_reg;
            r_s1_load <= i_req.load_value;
        end
        if (s1_advance) begin
            r_out_result  <= alu_result;
            r_out_written <= n_out_written;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_s1_vld <= i_req.valid;
            end
            if (out_free) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.result_value = r_out_result;
    assign o_rsp.was_written  = r_out_written;
endmodule

// File: test/rv32i_register_alu_execute_checker.sv
// Result checker for the register-register ALU: keeps a shadow register file,
// predicts every write-back and compares it with the response channel.
// Depends on rvalu_pkg and the request/response interfaces in rvalu_if.sv.
module rv32i_register_alu_execute_checker #(
    parameter int REG_COUNT = rvalu_pkg::REG_COUNT_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rvalu_req_if i_req,
    rvalu_rsp_if i_rsp,
    output int   o_fail_count,
    output int   o_pending
);
    import rvalu_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [XLEN-1:0] value;
        logic            written;
    } t_writeback;

    logic [XLEN-1:0] shadow_regs [32];
    t_writeback      predicted_writebacks [$];
    int              failures;

    // x0 and indexes past the configured file size read as zero.
    function automatic logic [XLEN-1:0] read_shadow(input logic [REG_IDX_W-1:0] idx);
        if (idx == '0 || idx >= REG_COUNT) begin
            return '0;
        end
        return shadow_regs[idx];
    endfunction

    function automatic t_writeback execute_instr(input logic [3:0]           op,
                                                 input logic [REG_IDX_W-1:0] rd,
                                                 input logic [REG_IDX_W-1:0] ra,
                                                 input logic [REG_IDX_W-1:0] rb,
                                                 input logic [XLEN-1:0]      load_value);
        logic [XLEN-1:0]    a;
        logic [XLEN-1:0]    b;
        logic [SHAMT_W-1:0] shamt;
        logic               known_op;
        t_writeback         wb;
        a        = read_shadow(ra);
        b        = read_shadow(rb);
        shamt    = b[SHAMT_W-1:0] & SHIFT_MASK;
        known_op = 1'b1;
        case (op)
            OP_ADD:  wb.value = a + b;
            OP_SUB:  wb.value = a - b;
            OP_XOR:  wb.value = a ^ b;
            OP_OR:   wb.value = a | b;
            OP_AND:  wb.value = a & b;
            OP_SLL:  wb.value = a << shamt;
            OP_SRL:  wb.value = a >> shamt;
            OP_SRA:  wb.value = $signed(a) >>> shamt;
            OP_SLT:  wb.value = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            OP_SLTU: wb.value = (a < b) ? 32'd1 : 32'd0;
            OP_LOAD: wb.value = load_value;
            default: begin
                // Unassigned opcodes produce zero and leave the file alone.
                known_op = 1'b0;
                wb.value = '0;
            end
        endcase
        wb.written = known_op && rd != '0 && rd < REG_COUNT;
        return wb;
    endfunction

    always @(posedge i_clk) begin
        t_writeback got;
        t_writeback want;
        t_writeback wb;
        if (!i_rst_n) begin
            for (int i = 0; i < 32; i++) begin
                shadow_regs[i] = '0;
            end
            predicted_writebacks.delete();
            failures = 0;
        end else begin
            // The response always belongs to an older request, so it is
            // retired before this cycle's request is predicted.
            if (i_rsp.valid && i_rsp.ready) begin
                got.value   = i_rsp.result_value;
                got.written = i_rsp.was_written;
                if (predicted_writebacks.size() == 0) begin
                    failures++;
                    if (failures <= REPORT_LIMIT) begin
                        $display("%0t: unexpected result value=%h written=%b",
                                 $time, got.value, got.written);
                    end
                end else begin
                    want = predicted_writebacks.pop_front();
                    if (got !== want) begin
                        failures++;
                        if (failures <= REPORT_LIMIT) begin
                            $display("%0t: mismatch value exp=%h got=%h written exp=%b got=%b",
                                     $time, want.value, got.value, want.written, got.written);
                        end
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                wb = execute_instr(i_req.operation, i_req.dest_reg, i_req.src_reg_a,
                                   i_req.src_reg_b, i_req.load_value);
                if (wb.written) begin
                    shadow_regs[i_req.dest_reg] = wb.value;
                end
                predicted_writebacks.push_back(wb);
            end
        end
        o_fail_count <= failures;
        o_pending    <= predicted_writebacks.size();
    end

endmodule

// File: test/rv32i_register_alu_execute_test.sv
// Top of the register-register ALU testbench: clock, reset, request stimulus
// and result back-pressure. Uses rvalu_pkg, rvalu_if.sv and the checker module.
module rv32i_register_alu_execute_test;
    import rvalu_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 3;
    localparam int RANDOM_ITEMS = 930;
    // Longest wait either side draws before a request or a result.
    localparam int MAX_IDLE     = 18;
    // Settling time for the pipeline, with margin, after the queue empties.
    localparam int DRAIN_CYCLES = 10;
    // Worst case is about 960 requests, each waiting out the longest idle draw on both sides.
    // The watchdog time is given in simulation time units, not in cycles.
    localparam int WATCHDOG     = 2_000_000;

    // Opcodes the block does not assign; they must be ignored.
    localparam logic [3:0] OP_UNUSED_LO = 4'd11;
    localparam logic [3:0] OP_UNUSED_HI = 4'd15;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    // When set, the sender issues back-to-back requests with no idle cycles.
    bit   sender_steady;

    rvalu_req_if req_ch ();
    rvalu_rsp_if rsp_ch ();

    rv32i_register_alu_execute u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    rv32i_register_alu_execute_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Issues one request after a random number of idle cycles and returns at
    // the edge where it is accepted. Valid stays high when the next request
    // follows without a gap, so it is never lowered and raised in one step.
    task automatic send_request(input logic [3:0]           op,
                                input logic [REG_IDX_W-1:0] rd,
                                input logic [REG_IDX_W-1:0] ra,
                                input logic [REG_IDX_W-1:0] rb,
                                input logic [XLEN-1:0]      value);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.operation  <= op;
        req_ch.dest_reg   <= rd;
        req_ch.src_reg_a  <= ra;
        req_ch.src_reg_b  <= rb;
        req_ch.load_value <= value;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // Waits until the checker holds no outstanding prediction. The first edge
    // lets the checker register a request accepted at the current edge.
    task automatic wait_until_drained();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Request side: directed program, then random program, then the verdict.
    initial begin
        logic [3:0]           op;
        logic [REG_IDX_W-1:0] rd;
        logic [REG_IDX_W-1:0] ra;
        logic [REG_IDX_W-1:0] rb;
        logic [XLEN-1:0]      value;
        int                   top_reg;
        int                   pick;

        sender_steady     = 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.operation  <= OP_ADD;
        req_ch.dest_reg   <= '0;
        req_ch.src_reg_a  <= '0;
        req_ch.src_reg_b  <= '0;
        req_ch.load_value <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Seed registers with the corner values of a 32-bit word.
        send_request(OP_LOAD, 5'd1,  5'd0, 5'd0, 32'hFFFF_FFFF);
        send_request(OP_LOAD, 5'd2,  5'd0, 5'd0, 32'h8000_0000);
        send_request(OP_LOAD, 5'd3,  5'd0, 5'd0, 32'h7FFF_FFFF);
        send_request(OP_LOAD, 5'd4,  5'd0, 5'd0, 32'h0000_001F);
        send_request(OP_LOAD, 5'd5,  5'd0, 5'd0, 32'h0000_0001);
        send_request(OP_LOAD, 5'd31, 5'd0, 5'd0, 32'hA5A5_5A5A);
        // Arithmetic wraps in both directions.
        send_request(OP_ADD,  5'd6,  5'd3, 5'd5, '0);
        send_request(OP_ADD,  5'd7,  5'd1, 5'd1, '0);
        send_request(OP_SUB,  5'd8,  5'd0, 5'd5, '0);
        send_request(OP_SUB,  5'd9,  5'd2, 5'd5, '0);
        send_request(OP_XOR,  5'd10, 5'd1, 5'd31, '0);
        send_request(OP_OR,   5'd11, 5'd2, 5'd5, '0);
        send_request(OP_AND,  5'd12, 5'd31, 5'd1, '0);
        // Shifts by zero and by 31, including an amount taken from the low
        // five bits of an all-ones register.
        send_request(OP_SLL,  5'd13, 5'd5, 5'd4, '0);
        send_request(OP_SLL,  5'd14, 5'd1, 5'd0, '0);
        send_request(OP_SRL,  5'd15, 5'd2, 5'd4, '0);
        send_request(OP_SRL,  5'd16, 5'd1, 5'd1, '0);
        send_request(OP_SRA,  5'd17, 5'd2, 5'd4, '0);
        send_request(OP_SRA,  5'd18, 5'd3, 5'd4, '0);
        // Signed and unsigned compares disagree on the sign bit.
        send_request(OP_SLT,  5'd19, 5'd2, 5'd3, '0);
        send_request(OP_SLTU, 5'd21, 5'd2, 5'd3, '0);
        send_request(OP_SLTU, 5'd22, 5'd0, 5'd1, '0);
        // Writes to x0 are dropped, and x0 keeps reading as zero.
        send_request(OP_ADD,  5'd0,  5'd1, 5'd5, '0);
        send_request(OP_LOAD, 5'd0,  5'd0, 5'd0, 32'h1234_5678);
        send_request(OP_ADD,  5'd24, 5'd0, 5'd0, '0);
        // Unassigned opcodes return zero and store nothing.
        send_request(OP_UNUSED_LO, 5'd25, 5'd1, 5'd1, '0);
        send_request(OP_UNUSED_HI, 5'd26, 5'd1, 5'd1, '0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Every 50 requests, pick at random between gapped traffic and a back-to-back stretch.
            if (n % 50 == 0) begin
                sender_steady = ($urandom_range(0, 3) == 0);
            end
            // Halfway through, hold off until the pipeline has fully emptied.
            if (n == RANDOM_ITEMS / 2) begin
                req_ch.valid <= 1'b0;
                wait_until_drained();
            end

            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                op = OP_LOAD;
            end else if (pick < 97) begin
                op = 4'($urandom_range(OP_ADD, OP_SLTU));
            end else begin
                op = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
            end

            // Half the requests stay within x0..x7 so that results feed
            // straight back into the following requests.
            top_reg = ($urandom_range(0, 1) == 0) ? 7 : 31;
            rd = ($urandom_range(0, 19) == 0) ? 5'd0 : 5'($urandom_range(1, top_reg));
            ra = 5'($urandom_range(0, top_reg));
            rb = 5'($urandom_range(0, top_reg));

            case ($urandom_range(0, 5))
                0:       value = '0;
                1:       value = 32'hFFFF_FFFF;
                2:       value = 32'h8000_0000;
                3:       value = 32'h7FFF_FFFF;
                4:       value = $urandom_range(0, 40);
                default: value = $urandom;
            endcase

            send_request(op, rd, ra, rb, value);
        end

        req_ch.valid <= 1'b0;
        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Result side: each result waits out a random stall before ready rises,
    // with occasional stretches where ready stays high throughout.
    initial begin
        int stall;
        int results;
        bit receiver_steady;

        results         = 0;
        receiver_steady = 1'b0;
        rsp_ch.ready    <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (results % 40 == 0) begin
                receiver_steady = ($urandom_range(0, 3) == 0);
            end
            stall = receiver_steady ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
            results++;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        #(WATCHDOG);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/rvalu_pkg.sv
hw/rtl/rvalu_if.sv
hw/rtl/rvalu_regfile.sv
hw/rtl/rvalu_alu.sv
hw/rtl/rv32i_register_alu_execute.sv
test/rv32i_register_alu_execute_checker.sv
test/rv32i_register_alu_execute_test.sv
